[rtl/core/bhte_pkg.sv]
// ----------------------------------------------------------------------------
// bhte_pkg
// Shared types and codes of the bucket hash table engine: request and
// result codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bhte_pkg;

  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int BIN_W  = 15;
  localparam int DIV_W  = 32;
  localparam int CFG_LOG2_W = 4;
  localparam int CFG_THR_W  = 9;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // configuration register index (paddr bit 2)
  localparam logic REG_BUCKET_LOG2 = 1'b0;
  localparam logic REG_EXPAND_THR  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    clr_step;
    logic    mod_step;
    logic    set_home;
    logic    next_hop;
    logic    wr_empty;
    logic    wr_clear;
    logic    wr_link;
    logic    found;
    logic    set_res;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic key_zero;
    logic bin_ok;
    logic is_insert;
    logic is_remove;
    logic match;
    logic any_empty;
    logic has_link;
    logic pool_full;
    logic out_free;
  } stat_t;

endpackage

[rtl/core/bhte_ram.sv]
// ----------------------------------------------------------------------------
// bhte_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bhte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1280,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bhte_ctrl.sv]
// ----------------------------------------------------------------------------
// bhte_ctrl
// Request sequencer: clearing pass after reset, bucket selection, chain
// walk and the final table update and result hand-off.
// ----------------------------------------------------------------------------
module bhte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bhte_pkg::stat_t st,
  output bhte_pkg::cmd_t  cmd
);

  import bhte_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = ST_OK;
    in_stall     = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (st.key_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_INVALID;
          state_next   = S_DONE;
        end else if (st.bin_ok) begin
          cmd.set_home = 1'b1;
          state_next   = S_READ;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.is_insert) begin
          if (st.match) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_PRESENT;
            state_next   = S_DONE;
          end else if (st.has_link) begin
            cmd.next_hop = 1'b1;
            state_next   = S_READ;
          end else if (st.any_empty) begin
            cmd.wr_empty = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_DONE;
          end else if (st.pool_full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NO_SPACE;
            state_next   = S_DONE;
          end else begin
            cmd.wr_link  = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_DONE;
          end
        end else begin
          if (st.match) begin
            cmd.found    = 1'b1;
            cmd.wr_clear = st.is_remove;
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_DONE;
          end else if (st.has_link) begin
            cmd.next_hop = 1'b1;
            state_next   = S_READ;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOT_FOUND;
            state_next   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/core/bhte_dp.sv]
// ----------------------------------------------------------------------------
// bhte_dp
// Datapath: request registers, bucket remainder unit, key/value/link
// memories, slot compare, overflow pool and the output register.
// ----------------------------------------------------------------------------
module bhte_dp #(
  parameter int MAX_BUCKETS      = 1024,
  parameter int SLOTS_PER_BUCKET = 3,
  parameter int OVERFLOW_BUCKETS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bhte_pkg::cmd_t                      cmd,
  output bhte_pkg::stat_t                     st,
  input  logic [bhte_pkg::CFG_LOG2_W-1:0]     bucket_count_log2,
  input  logic [bhte_pkg::CFG_THR_W-1:0]      expand_threshold,
  input  logic [1:0]                          req_type,
  input  logic [bhte_pkg::KEY_W-1:0]          key,
  input  logic [bhte_pkg::VAL_W-1:0]          value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          status,
  output logic [bhte_pkg::VAL_W-1:0]          value_out,
  output logic                                resize_needed
);

  import bhte_pkg::*;

  localparam int TOTAL = MAX_BUCKETS + OVERFLOW_BUCKETS;
  localparam int BW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int PW    = $clog2(OVERFLOW_BUCKETS + 1);
  localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam logic [BW-1:0]    MAX_B    = BW'(MAX_BUCKETS);
  localparam logic [BW-1:0]    LAST_ROW = BW'(TOTAL - 1);

  // reciprocal of the bucket count, exact for every masked key
  localparam int     RSH     = BIN_W + $clog2(MAX_BUCKETS);
  localparam int     RW      = BIN_W + 2;
  localparam int     PRW     = BIN_W + RW;
  localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(MAX_BUCKETS) - 1) /
                               longint'(MAX_BUCKETS);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  // request registers
  logic [1:0]       req_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // walk registers
  logic [BIN_W-1:0] rem;
  logic [BIN_W-1:0] quot;
  logic [BW-1:0]    bucket;
  logic             emp_found;
  logic [BW-1:0]    emp_bucket;
  logic [SW-1:0]    emp_slot;
  logic [BW-1:0]    clr_addr;
  logic [PW-1:0]    pool;

  // pending result
  status_t          res_status;
  logic [VAL_W-1:0] res_value;
  logic             res_resize;

  // memory read data
  logic [KEY_W-1:0] key_rd [SLOTS_PER_BUCKET];
  logic [VAL_W-1:0] val_rd [SLOTS_PER_BUCKET];
  logic [PW-1:0]    link_rd;

  // memory write controls
  logic [SLOTS_PER_BUCKET-1:0] key_we;
  logic [SLOTS_PER_BUCKET-1:0] val_we;
  logic [BW-1:0]               mem_waddr;
  logic [KEY_W-1:0]            key_wdata;
  logic                        link_we;
  logic [BW-1:0]               link_waddr;
  logic [PW-1:0]               link_wdata;

  // row compare results
  logic             row_match;
  logic [SW-1:0]    match_slot;
  logic             row_empty;
  logic [SW-1:0]    empty_slot;
  logic [BW-1:0]    ins_bucket;
  logic [SW-1:0]    ins_slot;
  logic [BW-1:0]    new_bucket;
  logic [VAL_W-1:0] match_val;
  logic [BIN_W-1:0] bin_mask;
  logic [BIN_W-1:0] bin_in;
  logic [PRW-1:0]   quot_prod;

  assign bin_mask   = ~({BIN_W{1'b1}} << bucket_count_log2);
  assign bin_in     = key[BIN_W-1:0] & bin_mask;
  assign quot_prod  = PRW'(bin_in) * PRW'(RECIP);
  assign new_bucket = MAX_B + BW'(pool);

  // first matching and first empty slot of the row
  always_comb begin
    row_match  = 1'b0;
    match_slot = '0;
    row_empty  = 1'b0;
    empty_slot = '0;
    match_val  = val_rd[0];
    for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
      if (!row_match && key_rd[j] == key_r) begin
        row_match  = 1'b1;
        match_slot = SW'(j);
        match_val  = val_rd[j];
      end
      if (!row_empty && key_rd[j] == '0) begin
        row_empty  = 1'b1;
        empty_slot = SW'(j);
      end
    end
  end

  assign ins_bucket = emp_found ? emp_bucket : bucket;
  assign ins_slot   = emp_found ? emp_slot   : empty_slot;

  // status to the controller
  always_comb begin
    st.clr_last  = (clr_addr == LAST_ROW);
    st.key_zero  = (key_r == '0);
    st.bin_ok    = (DIV_W'(rem) < DIV_W'(MAX_BUCKETS));
    st.is_insert = (req_r == REQ_INSERT);
    st.is_remove = (req_r == REQ_REMOVE);
    st.match     = row_match;
    st.any_empty = emp_found | row_empty;
    st.has_link  = (link_rd != '0);
    st.pool_full = (DIV_W'(pool) >= DIV_W'(OVERFLOW_BUCKETS));
    st.out_free  = !out_valid || !out_stall;
  end

  // memory write selection
  always_comb begin
    key_we     = '0;
    val_we     = '0;
    mem_waddr  = bucket;
    key_wdata  = key_r;
    link_we    = 1'b0;
    link_waddr = bucket;
    link_wdata = PW'(DIV_W'(pool) + DIV_W'(1));
    if (cmd.clr_step) begin
      key_we     = '1;
      mem_waddr  = clr_addr;
      key_wdata  = '0;
      link_we    = 1'b1;
      link_waddr = clr_addr;
      link_wdata = '0;
    end else if (cmd.wr_empty) begin
      key_we[ins_slot] = 1'b1;
      val_we[ins_slot] = 1'b1;
      mem_waddr        = ins_bucket;
    end else if (cmd.wr_clear) begin
      key_we[match_slot] = 1'b1;
      key_wdata          = '0;
    end else if (cmd.wr_link) begin
      key_we[0] = 1'b1;
      val_we[0] = 1'b1;
      mem_waddr = new_bucket;
      link_we   = 1'b1;
    end
  end

  // slot memories, one key and one value RAM per slot position
  for (genvar g = 0; g < SLOTS_PER_BUCKET; g++) begin : g_slot
    bhte_ram #(.WIDTH(KEY_W), .DEPTH(TOTAL), .AW(BW)) u_key_ram (
      .clk   (clk),
      .we    (key_we[g]),
      .waddr (mem_waddr),
      .wdata (key_wdata),
      .raddr (bucket),
      .rdata (key_rd[g])
    );
    bhte_ram #(.WIDTH(VAL_W), .DEPTH(TOTAL), .AW(BW)) u_val_ram (
      .clk   (clk),
      .we    (val_we[g]),
      .waddr (mem_waddr),
      .wdata (val_r),
      .raddr (bucket),
      .rdata (val_rd[g])
    );
  end

  // chain links: zero is no successor, else pool index plus one
  bhte_ram #(.WIDTH(PW), .DEPTH(TOTAL), .AW(BW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (bucket),
    .rdata (link_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pool     <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + BW'(1);
      end
      if (cmd.wr_link) begin
        pool <= pool + PW'(1);
      end
    end
  end

  // request, remainder and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= req_type;
      key_r     <= key;
      val_r     <= value;
      rem       <= bin_in;
      quot      <= BIN_W'(quot_prod >> RSH);
      emp_found <= 1'b0;
    end
    // one subtract of quotient times bucket count leaves the remainder
    if (cmd.mod_step) begin
      rem <= rem - BIN_W'(DIV_W'(quot) * DIV_W'(MAX_BUCKETS));
    end
    if (cmd.set_home) begin
      bucket <= BW'(rem);
    end
    if (cmd.next_hop) begin
      bucket <= MAX_B + BW'(link_rd) - BW'(1);
      if (!emp_found && row_empty) begin
        emp_found  <= 1'b1;
        emp_bucket <= bucket;
        emp_slot   <= empty_slot;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_value  <= cmd.found ? match_val : '0;
      res_resize <= cmd.wr_link &&
                    (DIV_W'(pool) + DIV_W'(1) >= DIV_W'(expand_threshold));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= res_status;
      value_out     <= res_value;
      resize_needed <= res_resize;
    end
  end

endmodule

[rtl/core/bucket_hash_table_engine.sv]
// ----------------------------------------------------------------------------
// bucket_hash_table_engine
// Key-value table with multi-slot buckets and overflow chains, driven by a
// sequencer over slot, value and link memories.
// ----------------------------------------------------------------------------
// One request at a time. The walk takes each bucket of the chain in one
// registered read of the bucket row from the slot and link memories. When
// the bucket mask is wider than the table, the home bucket is reduced
// modulo MAX_BUCKETS by a reciprocal multiply taken at accept and a single
// subtract. After reset a clearing pass over all MAX_BUCKETS + OVERFLOW_BUCKETS
// rows (1280 by default) empties the key and link memories; no request is
// taken until it ends, while the register port works throughout. A finished
// result sits in an output register, so the next request is taken while it
// waits.
module bucket_hash_table_engine #(
  parameter int MAX_BUCKETS      = 1024,
  parameter int SLOTS_PER_BUCKET = 3,
  parameter int OVERFLOW_BUCKETS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] key,
  input  logic [63:0] value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] value_out,
  output logic        resize_needed
);

  import bhte_pkg::*;

  logic [CFG_LOG2_W-1:0] bucket_count_log2;
  logic [CFG_THR_W-1:0]  expand_threshold;
  logic                  cfg_wr;
  cmd_t                  cmd;
  stat_t                 st;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count_log2 <= CFG_LOG2_W'(10);
      expand_threshold  <= CFG_THR_W'(64);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BUCKET_LOG2: bucket_count_log2 <= pwdata[CFG_LOG2_W-1:0];
        REG_EXPAND_THR:  expand_threshold  <= pwdata[CFG_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_BUCKET_LOG2: prdata = 32'(bucket_count_log2);
      REG_EXPAND_THR:  prdata = 32'(expand_threshold);
      default:         prdata = '0;
    endcase
  end

  bhte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bhte_dp #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .OVERFLOW_BUCKETS (OVERFLOW_BUCKETS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .bucket_count_log2 (bucket_count_log2),
    .expand_threshold  (expand_threshold),
    .req_type          (req_type),
    .key               (key),
    .value             (value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .value_out         (value_out),
    .resize_needed     (resize_needed)
  );

endmodule
